>>> src/voice_slot_allocator_defines.svh
// ----------------------------------------------------------------------------
// Voice slot allocator assertion macros
// Shared property forms used by the checker of the voice slot allocator.
// ----------------------------------------------------------------------------
`ifndef VOICE_SLOT_ALLOCATOR_DEFINES_SVH
`define VOICE_SLOT_ALLOCATOR_DEFINES_SVH

// The consequent must hold at the same clock edge as the antecedent.
`define VSA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("voice slot allocator check failed");

// The consequent must hold at the clock edge after the antecedent.
`define VSA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("voice slot allocator check failed");

`endif

>>> src/vsa_pkg.sv
// ----------------------------------------------------------------------------
// Voice slot allocator package
// Types and constants shared by the allocator, its memory and its channels.
// ----------------------------------------------------------------------------
package vsa_pkg;

	localparam int PRIO_W   = 8;
	localparam int GEN_W    = 17;
	localparam int HIDX_W   = 8;
	localparam int HANDLE_W = GEN_W + HIDX_W;
	localparam int COUNT_W  = 9;

	localparam logic [1:0] ACT_ALLOC    = 2'd0;
	localparam logic [1:0] ACT_VALIDATE = 2'd1;
	localparam logic [1:0] ACT_RELEASE  = 2'd2;

	localparam logic [COUNT_W-1:0] SLOTS_RESET    = 9'd32;
	localparam logic [GEN_W-1:0]   GEN_WRAP_LIMIT = 17'h0FFFF;
	localparam logic [GEN_W-1:0]   GEN_RESTART    = 17'd1;

	typedef struct packed {
		logic              busy;
		logic [PRIO_W-1:0] prio;
		logic [GEN_W-1:0]  gen;
	} slot_t;

endpackage

>>> src/vsa_cmd_if.sv
// ----------------------------------------------------------------------------
// Voice slot allocator command channel
// Carries one allocate, validate or release request per word.
// ----------------------------------------------------------------------------
interface vsa_cmd_if;
	import vsa_pkg::*;

	logic                valid;
	logic                ready;
	logic [1:0]          action;
	logic [PRIO_W-1:0]   request_priority;
	logic [HANDLE_W-1:0] handle_in;

	modport source (output valid, output action, output request_priority,
		output handle_in, input ready);
	modport sink (input valid, input action, input request_priority,
		input handle_in, output ready);
endinterface

>>> src/vsa_rsp_if.sv
// ----------------------------------------------------------------------------
// Voice slot allocator response channel
// Carries one result word per accepted command.
// ----------------------------------------------------------------------------
interface vsa_rsp_if;
	import vsa_pkg::*;

	logic                valid;
	logic                ready;
	logic                success;
	logic [HIDX_W-1:0]   slot_index;
	logic [HANDLE_W-1:0] handle_out;
	logic                was_stolen;

	modport source (output valid, output success, output slot_index,
		output handle_out, output was_stolen, input ready);
	modport sink (input valid, input success, input slot_index,
		input handle_out, input was_stolen, output ready);
endinterface

>>> src/vsa_cfg_if.sv
// ----------------------------------------------------------------------------
// Voice slot allocator configuration channel
// Writes the active slot count register.
// ----------------------------------------------------------------------------
interface vsa_cfg_if;
	import vsa_pkg::*;

	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] slots_in_use;

	modport source (output valid, output slots_in_use, input ready);
	modport sink (input valid, input slots_in_use, output ready);
endinterface

>>> src/vsa_slot_mem.sv
// ----------------------------------------------------------------------------
// Voice slot table memory
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module vsa_slot_mem #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  vsa_pkg::slot_t wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output vsa_pkg::slot_t rdata
);
	import vsa_pkg::*;

	slot_t mem [DEPTH];
	slot_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

>>> src/voice_slot_allocator.sv
// Allocate scans the active slots: the scan reads one slot per cycle
// from the single read port of the slot table and stops at the first empty slot.
// Validate and release with an index in range read their slot before the result.
// One command is worked at a time; the result register lets the next command in.
// After reset the table is cleared while cmd.ready stays low.
// ----------------------------------------------------------------------------
// Voice slot allocator
// Priority voice slot table with generation tagged handles.
// ----------------------------------------------------------------------------
module voice_slot_allocator #(
	parameter int MAX_SLOTS = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	vsa_cmd_if.sink        cmd,
	vsa_rsp_if.source      rsp,
	vsa_cfg_if.sink        cfg
);
	import vsa_pkg::*;

	localparam int IW = $clog2(MAX_SLOTS);
	localparam int CW = $clog2(MAX_SLOTS + 1);

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_CHECK  = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	logic [2:0]          state_q;
	logic [IW-1:0]       clr_cnt_q;
	logic [COUNT_W-1:0]  slots_q;
	logic [1:0]          act_q;
	logic [PRIO_W-1:0]   req_q;
	logic [CW-1:0]       issue_cnt_q;
	logic                rd_vld_s1;
	logic [IW-1:0]       rd_idx_s1;
	logic [PRIO_W-1:0]   limit_q;
	logic                found_q;
	logic [IW-1:0]       sel_idx_q;
	logic                sel_busy_q;
	logic [GEN_W-1:0]    sel_gen_q;

	logic                out_valid_q;
	logic                out_success_q;
	logic [HIDX_W-1:0]   out_index_q;
	logic [HANDLE_W-1:0] out_handle_q;
	logic                out_stolen_q;

	logic [COUNT_W-1:0]  n_sat;
	logic [CW-1:0]       n_act;
	logic [HIDX_W-1:0]   h_idx;
	logic [GEN_W-1:0]    h_gen;
	logic                h_in_range;
	logic                cmd_fire;
	logic                scan_hit_empty;
	logic                scan_take;
	logic                scan_issue;
	logic                scan_done;
	logic                finish_go;
	logic [GEN_W-1:0]    gen_new;

	logic                mem_we;
	logic [IW-1:0]       mem_waddr;
	slot_t               mem_wdata;
	logic                mem_re;
	logic [IW-1:0]       mem_raddr;
	slot_t               mem_rdata;

	assign n_sat = (slots_q > COUNT_W'(MAX_SLOTS)) ? COUNT_W'(MAX_SLOTS) : slots_q;
	assign n_act = n_sat[CW-1:0];

	assign h_idx      = cmd.handle_in[HIDX_W-1:0];
	assign h_gen      = cmd.handle_in[HANDLE_W-1:HIDX_W];
	assign h_in_range = COUNT_W'(h_idx) < n_sat;

	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign cfg.ready = 1'b1;

	assign scan_hit_empty = (state_q == ST_SCAN) && rd_vld_s1 && !mem_rdata.busy;
	assign scan_take      = (state_q == ST_SCAN) && rd_vld_s1 && mem_rdata.busy
		&& (limit_q >= mem_rdata.prio);
	assign scan_issue     = (state_q == ST_SCAN) && !scan_hit_empty && (issue_cnt_q < n_act);
	assign scan_done      = scan_hit_empty
		|| ((state_q == ST_SCAN) && !rd_vld_s1 && (issue_cnt_q >= n_act));

	assign finish_go = (state_q == ST_FINISH) && (!out_valid_q || rsp.ready);
	assign gen_new   = (sel_gen_q > GEN_WRAP_LIMIT) ? GEN_RESTART : sel_gen_q + GEN_RESTART;

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = h_idx[IW-1:0];
		if (scan_issue) begin
			mem_re    = 1'b1;
			mem_raddr = issue_cnt_q[IW-1:0];
		end else if (cmd_fire && h_in_range
			&& (cmd.action == ACT_VALIDATE || cmd.action == ACT_RELEASE)) begin
			mem_re = 1'b1;
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = sel_idx_q;
		mem_wdata = '0;
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_cnt_q;
		end else if (finish_go && found_q && act_q == ACT_ALLOC) begin
			mem_we         = 1'b1;
			mem_wdata.busy = 1'b1;
			mem_wdata.prio = req_q;
			mem_wdata.gen  = gen_new;
		end else if (finish_go && found_q && act_q == ACT_RELEASE) begin
			mem_we        = 1'b1;
			mem_wdata.gen = sel_gen_q;
		end
	end

	vsa_slot_mem #(
		.DEPTH (MAX_SLOTS),
		.AW    (IW)
	) u_slot_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q <= SLOTS_RESET;
		end else if (cfg.valid) begin
			slots_q <= cfg.slots_in_use;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			issue_cnt_q <= '0;
			rd_vld_s1   <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			rd_vld_s1 <= scan_issue;
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == IW'(MAX_SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_fire) begin
						found_q     <= 1'b0;
						issue_cnt_q <= '0;
						case (cmd.action)
							ACT_ALLOC: begin
								state_q <= (n_sat == '0) ? ST_FINISH : ST_SCAN;
							end
							ACT_VALIDATE, ACT_RELEASE: begin
								state_q <= h_in_range ? ST_CHECK : ST_FINISH;
							end
							default: begin
								state_q <= ST_FINISH;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_issue) begin
						issue_cnt_q <= issue_cnt_q + 1'b1;
					end
					if (scan_hit_empty || scan_take) begin
						found_q <= 1'b1;
					end
					if (scan_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_CHECK: begin
					found_q <= mem_rdata.busy && (mem_rdata.gen == sel_gen_q);
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (finish_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			act_q      <= cmd.action;
			req_q      <= cmd.request_priority;
			limit_q    <= cmd.request_priority;
			sel_idx_q  <= h_idx[IW-1:0];
			sel_gen_q  <= h_gen;
			sel_busy_q <= 1'b0;
		end else if (scan_hit_empty || scan_take) begin
			limit_q    <= scan_hit_empty ? limit_q : mem_rdata.prio;
			sel_idx_q  <= rd_idx_s1;
			sel_gen_q  <= mem_rdata.gen;
			sel_busy_q <= mem_rdata.busy;
		end
		if (scan_issue) begin
			rd_idx_s1 <= issue_cnt_q[IW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish_go) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish_go) begin
			out_success_q <= found_q;
			out_index_q   <= found_q ? HIDX_W'(sel_idx_q) : '0;
			out_handle_q  <= (found_q && act_q == ACT_ALLOC)
				? {gen_new, HIDX_W'(sel_idx_q)} : '0;
			out_stolen_q  <= found_q && (act_q == ACT_ALLOC) && sel_busy_q;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.success    = out_success_q;
	assign rsp.slot_index = out_index_q;
	assign rsp.handle_out = out_handle_q;
	assign rsp.was_stolen = out_stolen_q;
endmodule

>>> src/vsa_checker.sv
// ----------------------------------------------------------------------------
// Voice slot allocator checker
// Port level checks of command flow and response ordering.
// ----------------------------------------------------------------------------
`include "voice_slot_allocator_defines.svh"

module vsa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_valid,
	input logic        cmd_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic        success,
	input logic [7:0]  slot_index,
	input logic [24:0] handle_out,
	input logic        was_stolen
);
	// A waiting response word keeps its contents until taken.
	`VSA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable({success, slot_index, handle_out, was_stolen}))

	// A command is worked alone, so the port closes after each accepted word.
	`VSA_ASSERT_NEXT(a_one_cmd, cmd_valid && cmd_ready, !cmd_ready)

	// A new response only follows a cycle in which a command was being worked.
	`VSA_ASSERT_NOW(a_rsp_after_work, $rose(rsp_valid), $past(!cmd_ready))

	// A stolen slot is always a successful allocation naming that slot.
	`VSA_ASSERT_NOW(a_stolen_ok, rsp_valid && was_stolen, success && handle_out[7:0] == slot_index)
endmodule

bind voice_slot_allocator vsa_checker u_vsa_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cmd_valid  (cmd.valid),
	.cmd_ready  (cmd.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.success    (rsp.success),
	.slot_index (rsp.slot_index),
	.handle_out (rsp.handle_out),
	.was_stolen (rsp.was_stolen)
);

>>> tb/voice_slot_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voice slot allocator testbench
// Drives allocate, validate, release and unused action words against a shadow slot table,
// first from a directed table and then at random over several slot counts,
// and compares every response word with the shadow table's prediction or the row's own expected word.
// ----------------------------------------------------------------------------
module voice_slot_allocator_tb;
	import vsa_pkg::*;

	localparam int SLOT_LIMIT  = 256;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_WAIT  = 300;

	localparam logic [1:0] ACT_UNUSED = 2'd3;

	typedef struct packed {
		logic                success;
		logic [HIDX_W-1:0]   slot_index;
		logic [HANDLE_W-1:0] handle_out;
		logic                was_stolen;
	} alloc_result_t;

	typedef enum logic {ROW_COMMAND, ROW_COUNT_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t           kind;
		logic [1:0]          act;
		logic [PRIO_W-1:0]   req;
		logic [HANDLE_W-1:0] handle;
		logic [COUNT_W-1:0]  count;
		logic                typed;
		alloc_result_t       want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;

	vsa_cmd_if cmd_bus();
	vsa_rsp_if rsp_bus();
	vsa_cfg_if cfg_bus();

	voice_slot_allocator #(
		.MAX_SLOTS(SLOT_LIMIT)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_bus),
		.rsp(rsp_bus),
		.cfg(cfg_bus)
	);

	logic                shadow_busy [SLOT_LIMIT];
	logic [PRIO_W-1:0]   shadow_prio [SLOT_LIMIT];
	logic [GEN_W-1:0]    shadow_gen  [SLOT_LIMIT];
	logic [COUNT_W-1:0]  shadow_count;

	alloc_result_t       awaited_results[$];
	logic [HANDLE_W-1:0] issued_handles[$];
	plan_row_t           directed_plan[$];
	alloc_result_t       oldest;
	bit                  mismatch_seen = 1'b0;
	bit                  steady = 1'b0;
	int                  cycle_count = 0;

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic alloc_result_t apply_slot_action(input logic [1:0] act,
		input logic [PRIO_W-1:0] req, input logic [HANDLE_W-1:0] h);
		alloc_result_t r;
		int n;
		int pick;
		bit found;
		logic [PRIO_W-1:0] ceiling;
		logic [HIDX_W-1:0] hidx;
		logic [GEN_W-1:0] hgen;
		r = '0;
		n = (shadow_count > COUNT_W'(SLOT_LIMIT)) ? SLOT_LIMIT : int'(shadow_count);
		if (act == ACT_ALLOC) begin
			found = 1'b0;
			pick = 0;
			ceiling = req;
			for (int i = 0; i < n; i++) begin
				if (!shadow_busy[i]) begin
					pick = i;
					found = 1'b1;
					break;
				end
				if (ceiling >= shadow_prio[i]) begin
					ceiling = shadow_prio[i];
					pick = i;
					found = 1'b1;
				end
			end
			if (found) begin
				r.was_stolen = shadow_busy[pick];
				if (shadow_gen[pick] > GEN_WRAP_LIMIT)
					shadow_gen[pick] = GEN_RESTART;
				else
					shadow_gen[pick] = shadow_gen[pick] + 1'b1;
				shadow_busy[pick] = 1'b1;
				shadow_prio[pick] = req;
				r.success = 1'b1;
				r.slot_index = HIDX_W'(pick);
				r.handle_out = {shadow_gen[pick], HIDX_W'(pick)};
			end
		end else if (act == ACT_VALIDATE || act == ACT_RELEASE) begin
			hidx = h[HIDX_W-1:0];
			hgen = h[HANDLE_W-1:HIDX_W];
			if (int'(hidx) < n && shadow_gen[hidx] == hgen && shadow_busy[hidx]) begin
				r.success = 1'b1;
				r.slot_index = hidx;
				if (act == ACT_RELEASE) begin
					shadow_busy[hidx] = 1'b0;
					shadow_prio[hidx] = '0;
				end
			end
		end
		return r;
	endfunction

	function automatic plan_row_t cmd_row(input logic [1:0] act, input logic [PRIO_W-1:0] req,
		input logic [HANDLE_W-1:0] h);
		plan_row_t row;
		row = '0;
		row.kind = ROW_COMMAND;
		row.act = act;
		row.req = req;
		row.handle = h;
		return row;
	endfunction

	function automatic plan_row_t typed_row(input logic [1:0] act, input logic [PRIO_W-1:0] req,
		input logic [HANDLE_W-1:0] h, input alloc_result_t want);
		plan_row_t row;
		row = cmd_row(act, req, h);
		row.typed = 1'b1;
		row.want = want;
		return row;
	endfunction

	function automatic plan_row_t count_row(input logic [COUNT_W-1:0] v);
		plan_row_t row;
		row = '0;
		row.kind = ROW_COUNT_WRITE;
		row.count = v;
		return row;
	endfunction

	// Lowers valid and holds until every response word has come back.
	task automatic drain();
		cmd_bus.valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic write_slot_count(input logic [COUNT_W-1:0] v);
		drain();
		cfg_bus.valid <= 1'b1;
		cfg_bus.slots_in_use <= v;
		do
			@(posedge clk);
		while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		shadow_count = v;
	endtask

	task automatic maybe_pause();
		if (!steady) begin
			if ($urandom_range(99) < 3) begin
				drain();
			end else if ($urandom_range(99) < 18) begin
				cmd_bus.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	endtask

	task automatic issue(input logic [1:0] act, input logic [PRIO_W-1:0] req,
		input logic [HANDLE_W-1:0] h, input logic typed, input alloc_result_t want);
		alloc_result_t got;
		cmd_bus.valid <= 1'b1;
		cmd_bus.action <= act;
		cmd_bus.request_priority <= req;
		cmd_bus.handle_in <= h;
		do
			@(posedge clk);
		while (!cmd_bus.ready);
		got = apply_slot_action(act, req, h);
		if (act == ACT_ALLOC && got.success) begin
			issued_handles.push_back(got.handle_out);
			if (issued_handles.size() > 48)
				void'(issued_handles.pop_front());
		end
		awaited_results.push_back(typed ? want : got);
	endtask

	task automatic random_phase(input int items);
		logic [1:0] act;
		logic [PRIO_W-1:0] req;
		logic [HANDLE_W-1:0] h;
		int roll;
		for (int k = 0; k < items; k++) begin
			roll = $urandom_range(99);
			req = $urandom_range(1) ? PRIO_W'($urandom_range(255))
				: PRIO_W'($urandom_range(3) * 85);
			h = HANDLE_W'($urandom);
			if (roll < 42) begin
				act = ACT_ALLOC;
			end else if (roll < 88 && issued_handles.size() != 0) begin
				act = $urandom_range(1) ? ACT_VALIDATE : ACT_RELEASE;
				h = issued_handles[$urandom_range(issued_handles.size() - 1)];
				if ($urandom_range(9) == 0)
					h = h ^ (25'd1 << $urandom_range(HANDLE_W - 1));
			end else if (roll < 95) begin
				act = $urandom_range(1) ? ACT_VALIDATE : ACT_RELEASE;
				if ($urandom_range(1))
					h = HANDLE_W'(($urandom_range(4) << HIDX_W) | $urandom_range(40));
			end else begin
				act = ACT_UNUSED;
			end
			maybe_pause();
			issue(act, req, h, 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (awaited_results.size() == 0) begin
				$error("response word arrived with no command outstanding");
				mismatch_seen = 1'b1;
			end else begin
				oldest = awaited_results.pop_front();
				if (rsp_bus.success !== oldest.success) begin
					$error("success: expected %0d, got %0d", oldest.success, rsp_bus.success);
					mismatch_seen = 1'b1;
				end
				if (rsp_bus.slot_index !== oldest.slot_index) begin
					$error("slot_index: expected %0d, got %0d", oldest.slot_index,
						rsp_bus.slot_index);
					mismatch_seen = 1'b1;
				end
				if (rsp_bus.handle_out !== oldest.handle_out) begin
					$error("handle_out: expected 0x%h, got 0x%h", oldest.handle_out,
						rsp_bus.handle_out);
					mismatch_seen = 1'b1;
				end
				if (rsp_bus.was_stolen !== oldest.was_stolen) begin
					$error("was_stolen: expected %0d, got %0d", oldest.was_stolen,
						rsp_bus.was_stolen);
					mismatch_seen = 1'b1;
				end
			end
		end
		rsp_bus.ready <= steady || ($urandom_range(99) >= 18);
	end

	initial begin
		logic [COUNT_W-1:0] phase_count;
		arst_n = 1'b0;
		cmd_bus.valid = 1'b0;
		cmd_bus.action = ACT_ALLOC;
		cmd_bus.request_priority = '0;
		cmd_bus.handle_in = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.slots_in_use = SLOTS_RESET;
		rsp_bus.ready = 1'b0;
		for (int i = 0; i < SLOT_LIMIT; i++) begin
			shadow_busy[i] = 1'b0;
			shadow_prio[i] = '0;
			shadow_gen[i] = '0;
		end
		shadow_count = SLOTS_RESET;

		directed_plan.push_back(typed_row(ACT_ALLOC, 8'd0, '0, '{1'b1, 8'd0, 25'h100, 1'b0}));
		directed_plan.push_back(typed_row(ACT_ALLOC, 8'd255, '0, '{1'b1, 8'd1, 25'h101, 1'b0}));
		directed_plan.push_back(typed_row(ACT_VALIDATE, 8'd0, 25'h100, '{1'b1, 8'd0, '0, 1'b0}));
		directed_plan.push_back(typed_row(ACT_VALIDATE, 8'd0, 25'h200, '0));
		directed_plan.push_back(typed_row(ACT_RELEASE, 8'd0, 25'h101, '{1'b1, 8'd1, '0, 1'b0}));
		directed_plan.push_back(typed_row(ACT_RELEASE, 8'd0, 25'h101, '0));
		directed_plan.push_back(typed_row(ACT_VALIDATE, 8'd0, 25'h101, '0));
		directed_plan.push_back(typed_row(ACT_UNUSED, 8'd255, 25'h1FFFFFF, '0));
		directed_plan.push_back(typed_row(ACT_VALIDATE, 8'd0, 25'h120, '0));
		directed_plan.push_back(typed_row(ACT_VALIDATE, 8'd255, 25'h1FFFFFF, '0));
		directed_plan.push_back(count_row(9'd1));
		directed_plan.push_back(cmd_row(ACT_ALLOC, 8'd100, '0));
		directed_plan.push_back(typed_row(ACT_ALLOC, 8'd50, '0, '0));
		directed_plan.push_back(cmd_row(ACT_ALLOC, 8'd100, '0));
		directed_plan.push_back(count_row(9'd0));
		directed_plan.push_back(typed_row(ACT_ALLOC, 8'd255, '0, '0));
		directed_plan.push_back(typed_row(ACT_VALIDATE, 8'd0, 25'h300, '0));
		directed_plan.push_back(count_row(9'd511));
		directed_plan.push_back(cmd_row(ACT_VALIDATE, 8'd0, 25'h300));
		directed_plan.push_back(cmd_row(ACT_ALLOC, 8'd7, '0));
		directed_plan.push_back(count_row(9'd2));
		directed_plan.push_back(cmd_row(ACT_ALLOC, 8'd200, '0));
		directed_plan.push_back(cmd_row(ACT_ALLOC, 8'd100, '0));
		directed_plan.push_back(cmd_row(ACT_RELEASE, 8'd0, 25'h300));
		directed_plan.push_back(cmd_row(ACT_ALLOC, 8'd0, '0));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_plan[k]) begin
			if (directed_plan[k].kind == ROW_COUNT_WRITE) begin
				write_slot_count(directed_plan[k].count);
			end else begin
				maybe_pause();
				issue(directed_plan[k].act, directed_plan[k].req, directed_plan[k].handle,
					directed_plan[k].typed, directed_plan[k].want);
			end
		end

		for (int phase = 0; phase < 16; phase++) begin
			case (phase % 8)
				0: begin
					phase_count = COUNT_W'($urandom_range(1, 4));
				end
				1: begin
					phase_count = COUNT_W'($urandom_range(5, 16));
				end
				2: begin
					phase_count = 9'd1;
				end
				3: begin
					phase_count = COUNT_W'($urandom_range(17, 64));
				end
				4: begin
					phase_count = 9'd256;
				end
				5: begin
					phase_count = 9'd511;
				end
				6: begin
					phase_count = 9'd0;
				end
				default: begin
					phase_count = COUNT_W'($urandom_range(2, 300));
				end
			endcase
			write_slot_count(phase_count);
			steady = (phase == 2 || phase == 13);
			random_phase(40);
		end
		steady = 1'b0;

		drain();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (!mismatch_seen)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
